// ----- design/pfi_pkg.sv -----
// ----------------------------------------------------------------------------
// pfi_pkg: shared types and constants of the polyphase FIR interpolator
// Sizes, item layouts, control groups and the output rounding function.
// ----------------------------------------------------------------------------
package pfi_pkg;

  localparam int unsigned MAX_INTERP  = 8;
  localparam int unsigned MAX_PHASE   = 16;
  localparam int unsigned SAMPLE_BITS = 16;

  localparam int unsigned COEF_DEPTH = MAX_INTERP * MAX_PHASE;
  localparam int unsigned COEF_AW    = 7;
  localparam int unsigned STEP_W     = $clog2(MAX_PHASE);
  localparam int unsigned PHASE_W    = 3;
  localparam int unsigned LFAC_W     = 4;
  localparam int unsigned PLEN_W     = 5;
  localparam int unsigned PROD_W     = 2 * SAMPLE_BITS;
  localparam int unsigned ACC_W      = PROD_W + STEP_W + 1;
  localparam int unsigned FRAC_BITS  = SAMPLE_BITS - 1;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;

  localparam logic [LFAC_W-1:0] LFAC_RESET = LFAC_W'(2);
  localparam logic [PLEN_W-1:0] PLEN_RESET = PLEN_W'(16);

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_COEF   = 1'b1
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INTERP = 1'b0,
    CFG_PLEN   = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_WB
  } state_e;

  typedef struct packed {
    logic                          opcode;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [COEF_AW-1:0]            coef_index;
    logic signed [SAMPLE_BITS-1:0] coef_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic [PHASE_W-1:0]            phase;
    logic                          last;
  } out_item_t;

  typedef struct packed {
    logic shift;
    logic rotate;
  } cell_ctrl_t;

  typedef struct packed {
    logic en;
    logic first;
  } mac_ctrl_t;

  // Round half up to Q1.15 and clip to the sample range.
  function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
    input logic signed [ACC_W-1:0] acc
  );
    logic signed [ACC_W-1:0] sum;
    logic signed [ACC_W-1:0] r;
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    sum = acc + (ACC_W'(1) <<< (FRAC_BITS - 1));
    r   = sum >>> FRAC_BITS;
    hi  = (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
    lo  = -hi - ACC_W'(1);
    if (r > hi) begin
      r = hi;
    end else if (r < lo) begin
      r = lo;
    end
    return r[SAMPLE_BITS-1:0];
  endfunction

endpackage

// ----- design/pfi_if.sv -----
// ----------------------------------------------------------------------------
// pfi_if: request channels of the polyphase FIR interpolator
// Valid/ready channels for input items and for result items.
// ----------------------------------------------------------------------------
interface pfi_in_if import pfi_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pfi_out_if import pfi_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/pfi_cell.sv -----
// ----------------------------------------------------------------------------
// pfi_cell: one delay line cell
// Holds one sample; loads from the newer-side neighbor on a push and from
// the older-side neighbor while the line rotates past the multiplier.
// ----------------------------------------------------------------------------
module pfi_cell import pfi_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cell_ctrl_t                    ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0] shift_i,
  input  logic signed [SAMPLE_BITS-1:0] rotate_i,
  output logic signed [SAMPLE_BITS-1:0] q_o
);

  logic signed [SAMPLE_BITS-1:0] samp_q;
  logic signed [SAMPLE_BITS-1:0] samp_d;

  always_comb begin
    samp_d = samp_q;
    if (ctrl_i.shift) begin
      samp_d = shift_i;
    end else if (ctrl_i.rotate) begin
      samp_d = rotate_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samp_q <= '0;
    end else begin
      samp_q <= samp_d;
    end
  end

  assign q_o = samp_q;

endmodule

// ----- design/pfi_coef_ram.sv -----
// ----------------------------------------------------------------------------
// pfi_coef_ram: prototype coefficient store
// One write and one registered read per cycle; entries never written
// read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
module pfi_coef_ram import pfi_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          we_i,
  input  logic [COEF_AW-1:0]            waddr_i,
  input  logic signed [SAMPLE_BITS-1:0] wdata_i,
  input  logic [COEF_AW-1:0]            raddr_i,
  output logic signed [SAMPLE_BITS-1:0] rdata_o
);

  logic signed [SAMPLE_BITS-1:0] mem [COEF_DEPTH];
  logic [COEF_DEPTH-1:0]         vld_q;
  logic signed [SAMPLE_BITS-1:0] rdata_q;
  logic                          rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rvld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

// ----- design/pfi_mac.sv -----
// ----------------------------------------------------------------------------
// pfi_mac: shared multiply-accumulate
// Registers the sample beside the coefficient read, multiplies, then adds
// into a wide accumulator that the first step of a branch restarts.
// ----------------------------------------------------------------------------
module pfi_mac import pfi_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mac_ctrl_t                     ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0] samp_i,
  input  logic signed [SAMPLE_BITS-1:0] coef_i,
  output logic signed [ACC_W-1:0]       acc_o
);

  logic signed [SAMPLE_BITS-1:0] samp_q;
  mac_ctrl_t                     ctrl1_q;
  mac_ctrl_t                     ctrl2_q;
  logic signed [PROD_W-1:0]      prod_q;
  logic signed [ACC_W-1:0]       acc_q;
  logic signed [ACC_W-1:0]       acc_d;

  always_comb begin
    acc_d = ctrl2_q.first ? '0 : acc_q;
    if (ctrl2_q.en) begin
      acc_d = acc_d + ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i) begin
    samp_q <= samp_i;
    prod_q <= samp_q * coef_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl1_q <= '0;
      ctrl2_q <= '0;
      acc_q   <= '0;
    end else begin
      ctrl1_q <= ctrl_i;
      ctrl2_q <= ctrl1_q;
      acc_q   <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// ----- design/polyphase_fir_interpolator.sv -----
// ----------------------------------------------------------------------------
// polyphase_fir_interpolator: polyphase FIR upsampler
// A row of sample cells rotates past one shared MAC; each sample request
// yields one result per polyphase branch.
//
//   channel   dir  handshake          payload
//   in_i      in   valid/ready        opcode, sample, coef_index, coef_value
//   out_o     out  valid/ready        out_sample, phase, last
//   cfg       in   cfg_we_i           cfg_idx_i, cfg_data_i
//
// A coefficient request is written to the store as it is accepted. A sample
// request is accepted, then each branch runs in turn: the delay line rotates
// through all MAX_PHASE cells, one product per cycle into the single MAC for
// the first plen_q cells, then the MAC pipeline drains and the result
// register is written.
// Reset clears the cells and the coefficient valid bits at once; no sweep.
// A stalled output holds the branch in write-back until the register frees.
// ----------------------------------------------------------------------------
module polyphase_fir_interpolator import pfi_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pfi_in_if.sink                in_i,
  pfi_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  state_e                        state_q, state_d;
  logic [STEP_W-1:0]             step_q, step_d;
  logic [PHASE_W-1:0]            phase_q, phase_d;
  logic [COEF_AW-1:0]            addr_q, addr_d;
  logic                          drain_q, drain_d;
  logic [LFAC_W-1:0]             lfac_q;
  logic [PLEN_W-1:0]             plen_q;
  logic                          out_valid_q, out_valid_d;
  out_item_t                     out_data_q;
  logic                          load_out;
  logic                          in_take;
  logic                          coef_we;
  logic                          is_last;
  cell_ctrl_t                    cell_ctrl;
  mac_ctrl_t                     mac_ctrl;
  logic signed [SAMPLE_BITS-1:0] cell_q [MAX_PHASE];
  logic signed [SAMPLE_BITS-1:0] coef_rd;
  logic signed [ACC_W-1:0]       acc;

  // Configuration, stored already clamped to the supported range.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfac_q <= LFAC_RESET;
      plen_q <= PLEN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_INTERP: begin
          if (cfg_data_i[LFAC_W-1:0] == '0) begin
            lfac_q <= LFAC_W'(1);
          end else if (cfg_data_i[LFAC_W-1:0] > LFAC_W'(MAX_INTERP)) begin
            lfac_q <= LFAC_W'(MAX_INTERP);
          end else begin
            lfac_q <= cfg_data_i[LFAC_W-1:0];
          end
        end
        CFG_PLEN: begin
          if (cfg_data_i[PLEN_W-1:0] == '0) begin
            plen_q <= PLEN_W'(1);
          end else if (cfg_data_i[PLEN_W-1:0] > PLEN_W'(MAX_PHASE)) begin
            plen_q <= PLEN_W'(MAX_PHASE);
          end else begin
            plen_q <= cfg_data_i[PLEN_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_take    = in_i.valid && in_i.ready;
  assign coef_we    = in_take && (in_i.data.opcode == OP_COEF);
  assign is_last    = ({1'b0, phase_q} == (lfac_q - LFAC_W'(1)));

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    phase_d   = phase_q;
    addr_d    = addr_q;
    drain_d   = drain_q;
    cell_ctrl = '0;
    mac_ctrl  = '0;
    load_out  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_take && (in_i.data.opcode == OP_SAMPLE)) begin
          cell_ctrl.shift = 1'b1;
          step_d          = '0;
          phase_d         = '0;
          addr_d          = '0;
          state_d         = ST_RUN;
        end
      end
      ST_RUN: begin
        cell_ctrl.rotate = 1'b1;
        mac_ctrl.en      = ({1'b0, step_q} < plen_q);
        mac_ctrl.first   = (step_q == '0);
        step_d           = step_q + STEP_W'(1);
        addr_d           = addr_q + COEF_AW'(lfac_q);
        if (step_q == STEP_W'(MAX_PHASE - 1)) begin
          drain_d = 1'b0;
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        drain_d = 1'b1;
        if (drain_q) begin
          state_d = ST_WB;
        end
      end
      ST_WB: begin
        if (!out_valid_q || out_o.ready) begin
          load_out = 1'b1;
          if (is_last) begin
            state_d = ST_IDLE;
          end else begin
            phase_d = phase_q + PHASE_W'(1);
            addr_d  = COEF_AW'(phase_q) + COEF_AW'(1);
            step_d  = '0;
            state_d = ST_RUN;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      phase_q <= '0;
      addr_q  <= '0;
      drain_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      phase_q <= phase_d;
      addr_q  <= addr_d;
      drain_q <= drain_d;
    end
  end

  // Delay line: push moves toward older cells, rotation brings cell m to
  // the head at step m and wraps the head back to the tail.
  for (genvar k = 0; k < MAX_PHASE; k++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] shift_src;
    logic signed [SAMPLE_BITS-1:0] rot_src;

    if (k == 0) begin : g_head
      assign shift_src = in_i.data.sample;
    end else begin : g_body
      assign shift_src = cell_q[k-1];
    end
    assign rot_src = cell_q[(k + 1) % MAX_PHASE];

    pfi_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (cell_ctrl),
      .shift_i  (shift_src),
      .rotate_i (rot_src),
      .q_o      (cell_q[k])
    );
  end

  pfi_coef_ram u_coef_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (coef_we),
    .waddr_i (in_i.data.coef_index),
    .wdata_i (in_i.data.coef_value),
    .raddr_i (addr_q),
    .rdata_o (coef_rd)
  );

  pfi_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .samp_i (cell_q[0]),
    .coef_i (coef_rd),
    .acc_o  (acc)
  );

  // Result register: holds one branch result until the sink takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q.out_sample <= round_sat(acc);
      out_data_q.phase      <= phase_q;
      out_data_q.last       <= is_last;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

// ----- dv/polyphase_fir_interpolator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyphase_fir_interpolator_tb: self-checking bench for the FIR upsampler
// Sample and coefficient requests go in over the input channel, with random
// gaps, and results come out under random back-pressure. A scoreboard keeps
// its own coefficient store and delay line, works out every branch output,
// and checks each result against the oldest one due. The run steps through
// several factor and length settings, the out-of-range ones among them.
// ----------------------------------------------------------------------------
module polyphase_fir_interpolator_tb;
  import pfi_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned MAX_GAP       = 11;
  localparam int unsigned SETTLE_CYCLES = 2 * (MAX_PHASE + 3);
  localparam int unsigned LONG_HOLD     = 1500;
  localparam int unsigned PHASE_ITEMS   = 25;
  localparam longint      SAMPLE_MAX    = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint      SAMPLE_MIN    = -SAMPLE_MAX - 1;

  class branch_scoreboard;
    logic signed [SAMPLE_BITS-1:0] taps [COEF_DEPTH];
    logic signed [SAMPLE_BITS-1:0] history [MAX_PHASE];
    logic [LFAC_W-1:0]             factor_reg;
    logic [PLEN_W-1:0]             length_reg;
    out_item_t                     due_results [$];
    int unsigned                   mismatches;

    function new();
      foreach (taps[i]) taps[i] = '0;
      foreach (history[i]) history[i] = '0;
      factor_reg = LFAC_RESET;
      length_reg = PLEN_RESET;
      mismatches = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_INTERP) begin
        factor_reg = val[LFAC_W-1:0];
      end else begin
        length_reg = val[PLEN_W-1:0];
      end
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction

    function void note_request(in_item_t req);
      int unsigned lf;
      int unsigned tp;
      longint      acc;
      longint      rounded;
      out_item_t   res;
      if (req.opcode == OP_COEF) begin
        // every 7-bit index lies inside the store
        taps[req.coef_index] = req.coef_value;
        return;
      end
      lf = (factor_reg == 0) ? 1 : ((factor_reg > MAX_INTERP) ? MAX_INTERP : factor_reg);
      tp = (length_reg == 0) ? 1 : ((length_reg > MAX_PHASE) ? MAX_PHASE : length_reg);
      // shift the whole line, whatever length is in use
      for (int k = MAX_PHASE - 1; k > 0; k--) history[k] = history[k-1];
      history[0] = req.sample;
      for (int p = 0; p < lf; p++) begin
        acc = 0;
        for (int m = 0; m < tp; m++) begin
          acc += longint'(taps[p + m * lf]) * longint'(history[m]);
        end
        rounded = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (rounded > SAMPLE_MAX) begin
          rounded = SAMPLE_MAX;
        end else if (rounded < SAMPLE_MIN) begin
          rounded = SAMPLE_MIN;
        end
        res.out_sample = rounded[SAMPLE_BITS-1:0];
        res.phase      = PHASE_W'(p);
        res.last       = (p == lf - 1);
        due_results.push_back(res);
      end
    endfunction

    function void flag(string field, int want, int seen);
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected, expected none, actual %0d/%0d/%0d",
                 $time, got.out_sample, got.phase, got.last);
        return;
      end
      want = due_results.pop_front();
      if (got.out_sample !== want.out_sample) flag("out_sample", want.out_sample, got.out_sample);
      if (got.phase !== want.phase) flag("phase", want.phase, got.phase);
      if (got.last !== want.last) flag("last", want.last, got.last);
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  pfi_in_if  in_ch ();
  pfi_out_if out_ch ();

  branch_scoreboard sb;
  bit               src_idle = 1'b0;
  bit               snk_idle = 1'b0;
  bit               hold_request = 1'b0;
  int unsigned      cycle_count = 0;

  polyphase_fir_interpolator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("polyphase_fir_interpolator test failed");
      $finish;
    end
  end

  function automatic logic [SAMPLE_BITS-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2, 3: return SAMPLE_BITS'($urandom_range(0, 511)) - 16'd256;
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  function automatic in_item_t make_req(opcode_e op, logic [SAMPLE_BITS-1:0] smp,
                                        logic [COEF_AW-1:0] idx,
                                        logic [SAMPLE_BITS-1:0] val);
    in_item_t req;
    req.opcode     = op;
    req.sample     = smp;
    req.coef_index = idx;
    req.coef_value = val;
    return req;
  endfunction

  function automatic in_item_t random_request();
    return make_req(($urandom_range(0, 99) < 30) ? OP_COEF : OP_SAMPLE, pick_word(),
                    COEF_AW'($urandom()), pick_word());
  endfunction

  // Offer one request and hold it until the block takes it.
  task automatic send_item(input in_item_t req);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= req;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    sb.note_request(req);
  endtask

  // Drop valid and wait until the block has nothing left in flight.
  task automatic close_phase();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [LFAC_W-1:0] factor,
                               input logic [PLEN_W-1:0] taps_per_branch);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_INTERP;
    cfg_data_i <= CFG_DATA_W'(factor);
    @(posedge clk_i);
    sb.write_reg(CFG_INTERP, CFG_DATA_W'(factor));
    cfg_idx_i  <= CFG_PLEN;
    cfg_data_i <= CFG_DATA_W'(taps_per_branch);
    @(posedge clk_i);
    sb.write_reg(CFG_PLEN, CFG_DATA_W'(taps_per_branch));
    cfg_we_i   <= 1'b0;
  endtask

  task automatic run_phase(input logic [LFAC_W-1:0] factor,
                           input logic [PLEN_W-1:0] taps_per_branch,
                           input int unsigned count, input bit pressure);
    apply_setting(factor, taps_per_branch);
    src_idle = 1'($urandom_range(0, 1));
    snk_idle = 1'($urandom_range(0, 1));
    if (pressure) begin
      // keep offering back to back while the result side holds off
      src_idle     = 1'b0;
      hold_request = 1'b1;
    end
    repeat (count) send_item(random_request());
    close_phase();
  endtask

  initial begin : result_sink
    int unsigned gap;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        gap = snk_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (out_ch.valid !== 1'b1);
      sb.check_result(out_ch.data);
    end
  end

  initial begin : stimulus
    sb          = new();
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_INTERP;
    cfg_data_i  = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset setting, empty store: every branch must come out zero.
    src_idle = 1'b1;
    snk_idle = 1'b1;
    send_item(make_req(OP_SAMPLE, 16'h7fff, '0, '0));
    send_item(make_req(OP_SAMPLE, 16'h8000, 7'h7f, 16'hffff));
    // Coefficient writes leave the delay line alone.
    send_item(make_req(OP_COEF, 16'hffff, 7'd0, 16'h8000));
    send_item(make_req(OP_COEF, '0, 7'd1, 16'h7fff));
    send_item(make_req(OP_COEF, '0, 7'd2, 16'h8000));
    send_item(make_req(OP_COEF, '0, 7'd127, 16'hffff));
    send_item(make_req(OP_COEF, '0, 7'd3, 16'h0001));
    // Full-scale negative squared and summed: drive branch 0 into clipping.
    send_item(make_req(OP_SAMPLE, 16'h8000, '0, '0));
    send_item(make_req(OP_SAMPLE, 16'h8000, '0, '0));
    send_item(make_req(OP_SAMPLE, 16'h7fff, '0, '0));
    send_item(make_req(OP_SAMPLE, 16'h0000, '0, '0));
    send_item(make_req(OP_SAMPLE, 16'hffff, '0, '0));
    send_item(make_req(OP_SAMPLE, 16'h0001, '0, '0));
    close_phase();

    run_phase(4'd1, 5'd1, PHASE_ITEMS, 1'b0);
    run_phase(4'd8, 5'd16, PHASE_ITEMS, 1'b0);
    // zero factor and zero length act as one
    run_phase(4'd0, 5'd0, PHASE_ITEMS, 1'b0);
    // values past the maxima clip to them
    run_phase(4'd15, 5'd31, PHASE_ITEMS, 1'b0);
    run_phase(4'd9, 5'd17, PHASE_ITEMS, 1'b0);
    run_phase(4'd8, 5'd1, PHASE_ITEMS, 1'b0);
    // enlarge the length again: old samples come back into use
    run_phase(4'd8, 5'd16, 40, 1'b1);
    run_phase(4'd1, 5'd16, PHASE_ITEMS, 1'b0);
    run_phase(4'd3, 5'd5, PHASE_ITEMS, 1'b0);
    repeat (4) begin
      run_phase(LFAC_W'($urandom_range(0, 15)), PLEN_W'($urandom_range(0, 31)),
                PHASE_ITEMS, 1'b0);
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("polyphase_fir_interpolator test passed");
    end else begin
      $display("polyphase_fir_interpolator test failed");
    end
    $finish;
  end

endmodule
